// ===== rtl/fpd_pkg.sv =====
// fpd_pkg: shared types and constants of the framed packet deframer
`timescale 1ns / 1ps
package fpd_pkg;

   localparam int DATA_W          = 8;
   localparam int LEN_W           = 6;
   localparam int IDX_W           = 5;
   localparam int CSR_IDX_W       = 2;
   localparam int MAX_PAYLOAD_DEF = 32;

   localparam logic [DATA_W-1:0] START_BYTE_RESET = 8'd2;
   localparam logic [DATA_W-1:0] END_BYTE_RESET   = 8'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE   = 2'd1;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_TYPE,
      PH_LEN,
      PH_DATA,
      PH_CKS,
      PH_END,
      PH_EMIT_RD,
      PH_EMIT_LD
   } phase_type;

endpackage

// ===== rtl/fpd_ram.sv =====
// fpd_ram: generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module fpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/framed_packet_deframer_unit.sv =====
// framed_packet_deframer_unit: start/end framed, length prefixed, sum8 checked frame parser
`timescale 1ns / 1ps
// Takes one received byte per request and hunts for the start byte, then reads a type byte,
// a length byte, the payload, a checksum byte (sum of the payload modulo 256) and the end
// byte. While a frame is parsed one request is taken every cycle; payload bytes go into a
// ram of MAX_PAYLOAD bytes. When the end byte closes a frame whose checksum and end byte
// match, req_stall rises and the frame is read back from that ram as one response per
// payload byte (or one empty-payload response for a zero length frame). Each response
// passes a ram read state (PH_EMIT_RD) and then an output load state (PH_EMIT_LD), which
// waits while rsp_stall holds the output; requests stay stalled after the end byte until
// the last response of the frame is loaded. Bad frames and lengths above MAX_PAYLOAD are
// dropped without responses. csr writes are always ready.
module framed_packet_deframer_unit #(
   parameter int MAX_PAYLOAD = fpd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fpd_pkg::DATA_W-1:0]    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fpd_pkg::DATA_W-1:0]    rsp_pkt_type,
   output logic [fpd_pkg::LEN_W-1:0]     rsp_pkt_len,
   output logic [fpd_pkg::IDX_W-1:0]     rsp_byte_index,
   output logic [fpd_pkg::DATA_W-1:0]    rsp_data_byte,
   output logic                          rsp_empty_payload,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fpd_pkg::DATA_W-1:0]    csr_data
);
   import fpd_pkg::*;

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [DATA_W-1:0] MAX_LEN = DATA_W'(MAX_PAYLOAD);

   phase_type         phase_ff, phase_in;
   logic [DATA_W-1:0] start_byte_ff, end_byte_ff;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] type_ff, type_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic [DATA_W-1:0] cks_ff, cks_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;

   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_type_ff, out_type_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic              out_empty_ff, out_empty_in;
   logic              out_last_ff, out_last_in;

   logic              req_take;
   logic              out_free;
   logic              ram_wr_en;
   logic [DATA_W-1:0] ram_rd_data;
   logic [LEN_W-1:0]  count_next;
   logic [LEN_W-1:0]  idx_next;

   // payload store
   fpd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (phase_ff == PH_EMIT_RD) || (phase_ff == PH_EMIT_LD);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign ram_wr_en = req_take && (phase_ff == PH_DATA);
   assign count_next = count_ff + LEN_W'(1);
   assign idx_next   = idx_ff + LEN_W'(1);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         end_byte_ff   <= END_BYTE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_BYTE: start_byte_ff <= csr_data;
            CSR_END_BYTE:   end_byte_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         type_ff      <= '0;
         length_ff    <= '0;
         sum_ff       <= '0;
         cks_ff       <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         type_ff      <= type_in;
         length_ff    <= length_in;
         sum_ff       <= sum_in;
         cks_ff       <= cks_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_type_ff  <= out_type_in;
      out_len_ff   <= out_len_in;
      out_idx_ff   <= out_idx_in;
      out_data_ff  <= out_data_in;
      out_empty_ff <= out_empty_in;
      out_last_ff  <= out_last_in;
   end

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      type_in      = type_ff;
      length_in    = length_ff;
      sum_in       = sum_ff;
      cks_in       = cks_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_type_in  = out_type_ff;
      out_len_in   = out_len_ff;
      out_idx_in   = out_idx_ff;
      out_data_in  = out_data_ff;
      out_empty_in = out_empty_ff;
      out_last_in  = out_last_ff;

      case (phase_ff)
         PH_HUNT: begin
            if (req_take && (req_rx_byte == start_byte_ff)) begin
               phase_in = PH_TYPE;
               count_in = '0;
               sum_in   = '0;
            end
         end
         PH_TYPE: begin
            if (req_take) begin
               type_in  = req_rx_byte;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            if (req_take) begin
               if (req_rx_byte > MAX_LEN) begin
                  phase_in = PH_HUNT;
               end else begin
                  length_in = req_rx_byte[LEN_W-1:0];
                  count_in  = '0;
                  sum_in    = '0;
                  phase_in  = (req_rx_byte == '0) ? PH_CKS : PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (req_take) begin
               sum_in   = sum_ff + req_rx_byte;
               count_in = count_next;
               if (count_next >= length_ff) begin
                  phase_in = PH_CKS;
               end
            end
         end
         PH_CKS: begin
            if (req_take) begin
               cks_in   = req_rx_byte;
               phase_in = PH_END;
            end
         end
         PH_END: begin
            if (req_take) begin
               idx_in = '0;
               if ((cks_ff == sum_ff) && (req_rx_byte == end_byte_ff)) begin
                  phase_in = PH_EMIT_RD;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         end
         PH_EMIT_RD: begin
            // ram read of idx_ff in flight
            phase_in = PH_EMIT_LD;
         end
         PH_EMIT_LD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_type_in  = type_ff;
               out_len_in   = length_ff;
               out_idx_in   = idx_ff[IDX_W-1:0];
               if (length_ff == '0) begin
                  out_data_in  = '0;
                  out_empty_in = 1'b1;
                  out_last_in  = 1'b1;
               end else begin
                  out_data_in  = ram_rd_data;
                  out_empty_in = 1'b0;
                  out_last_in  = (idx_next == length_ff);
               end
               if ((length_ff == '0) || (idx_next == length_ff)) begin
                  phase_in = PH_HUNT;
               end else begin
                  idx_in   = idx_next;
                  phase_in = PH_EMIT_RD;
               end
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pkt_type      = out_type_ff;
   assign rsp_pkt_len       = out_len_ff;
   assign rsp_byte_index    = out_idx_ff;
   assign rsp_data_byte     = out_data_ff;
   assign rsp_empty_payload = out_empty_ff;
   assign rsp_last          = out_last_ff;

endmodule
